// ===== rtl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg: shared definitions for the anti-windup PID controller
// Register indexes, sequencer state codes, fixed-point constants and the
// saturating and clamping helpers used by the datapath.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_INTEG_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_OUT_LIMIT    = 3'd4;
   localparam logic [2:0] CSR_STEP_TIME    = 3'd5;
   localparam logic [2:0] CSR_FILTER_ALPHA = 3'd6;

   // Sequencer state codes.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_P    = 4'd1;
   localparam logic [3:0] ST_I1   = 4'd2;
   localparam logic [3:0] ST_I2   = 4'd3;
   localparam logic [3:0] ST_I3   = 4'd4;
   localparam logic [3:0] ST_DW   = 4'd5;
   localparam logic [3:0] ST_FA   = 4'd6;
   localparam logic [3:0] ST_FB   = 4'd7;
   localparam logic [3:0] ST_FC   = 4'd8;
   localparam logic [3:0] ST_FD   = 4'd9;
   localparam logic [3:0] ST_SUM  = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   // Q16.16 constants.
   localparam logic [16:0] Q_ONE      = 17'd65536;
   localparam logic [16:0] SAT_MARGIN = 17'd655;

   // Divider steps: two quotient bits per cycle over 32 quotient bits.
   localparam logic [3:0] DIV_LAST = 4'd15;

   // Floor shift of a Q32.32 product down to Q16.16, saturated to 32 bits.
   function automatic logic signed [31:0] sat_q(input logic signed [65:0] x);
      logic signed [49:0] s;
      s = x[65:16];
      if (s > 50'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (s < -50'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return s[31:0];
   endfunction

   // Saturate a 33-bit signed sum to 32 bits.
   function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
      if (x[32] != x[31]) begin
         return x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return x[31:0];
   endfunction

   // Symmetric clamp to plus or minus a nonnegative 31-bit limit.
   function automatic logic signed [31:0] clamp_sym(input logic signed [33:0] x,
                                                    input logic [30:0] lim);
      logic signed [33:0] l;
      logic signed [33:0] nl;
      l  = signed'({3'b000, lim});
      nl = -l;
      if (x > l) begin
         return l[31:0];
      end else if (x < nl) begin
         return nl[31:0];
      end
      return x[31:0];
   endfunction

endpackage

// ===== rtl/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup: positional PID controller with anti-windup
// Signed Q16.16 PID with a trapezoidal, clamped integral, a low-pass
// filtered derivative and a clamped output, built around one shared
// multiplier and a radix-4 restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: a control item steps through P, I1, I2, I3 and DW; with the
// derivative enabled it waits in DW for the divider, then steps through FA to
// FD; it ends with SUM and OUT. A clear item goes straight to OUT.
// Throughput: one item at a time; req_ready is high only while idle.
// The next item may enter while a result waits.
// Reset (synchronous, active high) clears the controller state, the
// configuration registers (filter_alpha returns to one) and the handshakes.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
   input  logic               clock,
   input  logic               reset,
   // Configuration write port.
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   // Input items.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_measured,
   // Result items.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic signed [31:0] rsp_integ_value
);
   import pidaw_pkg::*;

   // Configuration registers.
   logic signed [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [30:0]        integ_limit_ff, out_limit_ff, step_time_ff;
   logic [16:0]        filter_alpha_ff;

   // Controller state that persists from item to item.
   logic signed [31:0] integ_acc_ff, integ_acc_in;
   logic signed [32:0] last_error_ff, last_error_in;
   logic signed [31:0] filt_deriv_ff, filt_deriv_in;
   logic signed [31:0] last_drive_ff, last_drive_in;

   // Sequencer and per-item working registers.
   logic [3:0]         state_ff, state_in;
   logic signed [32:0] err_ff, err_in;
   logic signed [31:0] p_term_ff, p_term_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [65:0] facc_ff, facc_in;

   // Divider registers. The shift register starts with the low dividend bits
   // and fills with quotient bits from the bottom as the steps go by.
   logic [31:0]        div_rem_ff, div_rem_in;
   logic [31:0]        div_sh_ff, div_sh_in;
   logic [3:0]         div_cnt_ff, div_cnt_in;
   logic               div_busy_ff, div_busy_in;
   logic               div_ovf_ff, div_ovf_in;
   logic               div_neg_ff, div_neg_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_drive_ff, rsp_drive_in;
   logic signed [31:0] rsp_integ_ff, rsp_integ_in;

   // Shared multiplier operands.
   logic signed [32:0] mul_a, mul_b;

   // Datapath intermediates.
   logic               integ_en, deriv_en;
   logic signed [33:0] err_sum, err_diff;
   logic signed [32:0] half_sum;
   logic [33:0]        diff_mag;
   logic signed [31:0] term_q;
   logic [16:0]        alpha_lim, alpha_rest;
   logic signed [31:0] raw_deriv;
   logic [32:0]        drive_mag;
   logic signed [33:0] sat_thresh;
   logic               saturated, err_agrees;
   logic signed [31:0] acc_sum;
   logic signed [33:0] drive_sum;
   logic signed [65:0] filt_sum;
   logic [31:0]        r1, r2;
   logic               q1, q2;
   logic               out_free;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_integ_value = rsp_integ_ff;

   assign integ_en = (integ_gain_ff != 32'sd0) && (step_time_ff != 31'd0);
   assign deriv_en = (deriv_gain_ff != 32'sd0) && (step_time_ff != 31'd0);

   // Trapezoid half sum and first difference of the error.
   assign err_sum  = {err_ff[32], err_ff} + {last_error_ff[32], last_error_ff};
   assign half_sum = err_sum[33:1];
   assign err_diff = {err_ff[32], err_ff} - {last_error_ff[32], last_error_ff};
   assign diff_mag = err_diff[33] ? (~err_diff + 34'd1) : err_diff;

   // The product register holds the last Q32.32 product; this is its Q16.16 form.
   assign term_q = sat_q(prod_ff);

   // Filter weights: alpha above one acts as one.
   assign alpha_lim  = (filter_alpha_ff > Q_ONE) ? Q_ONE : filter_alpha_ff;
   assign alpha_rest = Q_ONE - alpha_lim;

   // The quotient is a magnitude; apply the sign and saturate to 32 bits.
   always_comb begin
      if (div_neg_ff) begin
         raw_deriv = (div_ovf_ff || div_sh_ff[31]) ? 32'sh8000_0000 : -signed'(div_sh_ff);
      end else begin
         raw_deriv = (div_ovf_ff || div_sh_ff[31]) ? 32'sh7FFF_FFFF : signed'(div_sh_ff);
      end
   end

   // Anti-windup: hold integration while the last drive sat near its limit
   // and the error pushes further in the same direction.
   assign drive_mag  = last_drive_ff[31] ? (33'd0 - {1'b1, last_drive_ff})
                                         : {1'b0, last_drive_ff};
   assign sat_thresh = signed'({3'b000, out_limit_ff}) - signed'({17'd0, SAT_MARGIN});
   assign saturated  = signed'({1'b0, drive_mag}) >= sat_thresh;
   assign err_agrees = (!err_ff[32] && (err_ff != 33'sd0) &&
                        !last_drive_ff[31] && (last_drive_ff != 32'sd0)) ||
                       (err_ff[32] && last_drive_ff[31]);

   assign acc_sum   = sat33({integ_acc_ff[31], integ_acc_ff} + {term_q[31], term_q});
   assign filt_sum  = facc_ff + prod_ff;
   assign drive_sum = {{2{p_term_ff[31]}}, p_term_ff} + {{2{integ_acc_ff[31]}}, integ_acc_ff}
                    + (deriv_en ? {{2{term_q[31]}}, term_q} : 34'sd0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Two restoring divider steps per cycle. The remainder stays below dt,
   // which is below two to the 31st, so the shifted value fits in 32 bits.
   always_comb begin
      r1 = {div_rem_ff[30:0], div_sh_ff[31]};
      q1 = (r1 >= {1'b0, step_time_ff});
      if (q1) begin
         r1 = r1 - {1'b0, step_time_ff};
      end
      r2 = {r1[30:0], div_sh_ff[30]};
      q2 = (r2 >= {1'b0, step_time_ff});
      if (q2) begin
         r2 = r2 - {1'b0, step_time_ff};
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (state_ff)
         ST_P: begin
            mul_a = {prop_gain_ff[31], prop_gain_ff};
            mul_b = err_ff;
         end
         ST_I1: begin
            mul_a = {integ_gain_ff[31], integ_gain_ff};
            mul_b = half_sum;
         end
         ST_I2: begin
            mul_a = {term_q[31], term_q};
            mul_b = signed'({2'b00, step_time_ff});
         end
         ST_FA: begin
            mul_a = signed'({16'd0, alpha_lim});
            mul_b = {raw_deriv[31], raw_deriv};
         end
         ST_FB: begin
            mul_a = signed'({16'd0, alpha_rest});
            mul_b = {filt_deriv_ff[31], filt_deriv_ff};
         end
         ST_FD: begin
            mul_a = {deriv_gain_ff[31], deriv_gain_ff};
            mul_b = {filt_deriv_ff[31], filt_deriv_ff};
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      p_term_in     = p_term_ff;
      facc_in       = facc_ff;
      integ_acc_in  = integ_acc_ff;
      last_error_in = last_error_ff;
      filt_deriv_in = filt_deriv_ff;
      last_drive_in = last_drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_drive_in  = rsp_drive_ff;
      rsp_integ_in  = rsp_integ_ff;
      div_rem_in    = div_rem_ff;
      div_sh_in     = div_sh_ff;
      div_cnt_in    = div_cnt_ff;
      div_busy_in   = div_busy_ff;
      div_ovf_in    = div_ovf_ff;
      div_neg_in    = div_neg_ff;

      if (div_busy_ff) begin
         div_rem_in = r2;
         div_sh_in  = {div_sh_ff[29:0], q1, q2};
         div_cnt_in = div_cnt_ff + 4'd1;
         if (div_cnt_ff == DIV_LAST) begin
            div_busy_in = 1'b0;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  // A clear item zeroes the state, which also makes the
                  // result zeros.
                  integ_acc_in  = 32'sd0;
                  last_error_in = 33'sd0;
                  filt_deriv_in = 32'sd0;
                  last_drive_in = 32'sd0;
                  state_in      = ST_OUT;
               end else begin
                  err_in   = {req_target[31], req_target} - {req_measured[31], req_measured};
                  state_in = ST_P;
               end
            end
         end
         ST_P: begin
            // Start (diff * 65536) / dt on magnitudes. A quotient of two to
            // the 32nd or more saturates, which the top dividend bits show.
            div_rem_in  = {14'd0, diff_mag[33:16]};
            div_sh_in   = {diff_mag[15:0], 16'd0};
            div_ovf_in  = ({13'd0, diff_mag[33:16]} >= step_time_ff);
            div_neg_in  = err_diff[33];
            div_cnt_in  = 4'd0;
            div_busy_in = 1'b1;
            state_in    = ST_I1;
         end
         ST_I1: begin
            p_term_in = term_q;
            state_in  = ST_I2;
         end
         ST_I2: begin
            state_in = ST_I3;
         end
         ST_I3: begin
            if (integ_en) begin
               if (!saturated || !err_agrees) begin
                  integ_acc_in = clamp_sym({{2{acc_sum[31]}}, acc_sum}, integ_limit_ff);
               end else begin
                  integ_acc_in = clamp_sym({{2{integ_acc_ff[31]}}, integ_acc_ff},
                                           integ_limit_ff);
               end
            end
            state_in = ST_DW;
         end
         ST_DW: begin
            if (!deriv_en) begin
               state_in = ST_SUM;
            end else if (!div_busy_ff) begin
               state_in = ST_FA;
            end
         end
         ST_FA: begin
            state_in = ST_FB;
         end
         ST_FB: begin
            facc_in  = prod_ff;
            state_in = ST_FC;
         end
         ST_FC: begin
            filt_deriv_in = sat_q(filt_sum);
            state_in      = ST_FD;
         end
         ST_FD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            last_drive_in = clamp_sym(drive_sum, out_limit_ff);
            last_error_in = err_ff;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // The result sits in the last drive and integral registers; it
            // moves to the output register once that register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = last_drive_ff;
               rsp_integ_in = integ_acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         div_busy_ff     <= 1'b0;
         integ_acc_ff    <= 32'sd0;
         last_error_ff   <= 33'sd0;
         filt_deriv_ff   <= 32'sd0;
         last_drive_ff   <= 32'sd0;
         prop_gain_ff    <= 32'sd0;
         integ_gain_ff   <= 32'sd0;
         deriv_gain_ff   <= 32'sd0;
         integ_limit_ff  <= 31'd0;
         out_limit_ff    <= 31'd0;
         step_time_ff    <= 31'd0;
         filter_alpha_ff <= Q_ONE;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_busy_ff   <= div_busy_in;
         integ_acc_ff  <= integ_acc_in;
         last_error_ff <= last_error_in;
         filt_deriv_ff <= filt_deriv_in;
         last_drive_ff <= last_drive_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PROP_GAIN:    prop_gain_ff    <= csr_wdata;
               CSR_INTEG_GAIN:   integ_gain_ff   <= csr_wdata;
               CSR_DERIV_GAIN:   deriv_gain_ff   <= csr_wdata;
               CSR_INTEG_LIMIT:  integ_limit_ff  <= csr_wdata[30:0];
               CSR_OUT_LIMIT:    out_limit_ff    <= csr_wdata[30:0];
               CSR_STEP_TIME:    step_time_ff    <= csr_wdata[30:0];
               CSR_FILTER_ALPHA: filter_alpha_ff <= csr_wdata[16:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      p_term_ff    <= p_term_in;
      prod_ff      <= prod_in;
      facc_ff      <= facc_in;
      div_rem_ff   <= div_rem_in;
      div_sh_ff    <= div_sh_in;
      div_cnt_ff   <= div_cnt_in;
      div_ovf_ff   <= div_ovf_in;
      div_neg_ff   <= div_neg_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_integ_ff <= rsp_integ_in;
   end

endmodule
